@@ hw/rtl/dbb_pkg.sv @@
// Shared types, codes and helpers for the draw batch binner.
// Used by the top level, which is also the bin RAM user.
package dbb_pkg;

	localparam int SKIN_W = 16;
	localparam int VCNT_W = 16;
	localparam int ICNT_W = 20;
	localparam int BIN_W  = 6;

	// Request modes; the fourth code is unused and only answers a completion.
	localparam logic [1:0] MODE_ADD       = 2'd0;
	localparam logic [1:0] MODE_FLUSH_ONE = 2'd1;
	localparam logic [1:0] MODE_FLUSH_ALL = 2'd2;
	localparam logic [1:0] MODE_RESERVED  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_BIG  = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE = 2'd2;

	// Result kinds.
	localparam logic KIND_DRAW = 1'b0;
	localparam logic KIND_CMPL = 1'b1;

	// Primitive codes.
	localparam logic [1:0] PRIM_TRI_LIST   = 2'd0;
	localparam logic [1:0] PRIM_LINE_STRIP = 2'd1;
	localparam logic [1:0] PRIM_POINT_LIST = 2'd2;

	// Shade modes.
	localparam logic [1:0] SHADE_POINTS    = 2'd2;
	localparam logic [1:0] SHADE_HULL_WIRE = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_VERTS  = 2'd0;
	localparam logic [1:0] REG_MAX_INDEX  = 2'd1;
	localparam logic [1:0] REG_SHADE_MODE = 2'd2;

	// One bin as it is stored in a RAM row.
	typedef struct packed {
		logic              tag_valid;
		logic [SKIN_W-1:0] skin;
		logic [VCNT_W-1:0] vcnt;
		logic [ICNT_W-1:0] icnt;
	} bin_t;

	// Divide an index count by three with a reciprocal multiply.
	// ceil(2^22/3) gives an exact floor for every 20-bit value.
	function automatic logic [ICNT_W-1:0] div3(input logic [ICNT_W-1:0] x);
		logic [ICNT_W+21:0] prod;
		prod = {22'd0, x} * {{ICNT_W{1'b0}}, 22'h155556};
		return prod[ICNT_W+21:22];
	endfunction

endpackage

@@ hw/rtl/dbb_in_if.sv @@
// Request channel of the draw batch binner.
// Depends on nothing but plain logic types.
interface dbb_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [2:0]  vertex_type;
	logic [15:0] skin_id;
	logic [15:0] num_verts;
	logic [19:0] num_indices;
	logic        has_indices;

	modport source(output valid, mode, vertex_type, skin_id, num_verts, num_indices,
		has_indices, input ready);
	modport sink(input valid, mode, vertex_type, skin_id, num_verts, num_indices,
		has_indices, output ready);
endinterface

@@ hw/rtl/dbb_out_if.sv @@
// Result channel of the draw batch binner.
// Depends on nothing but plain logic types.
interface dbb_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [1:0]  status;
	logic [5:0]  bin_number;
	logic [15:0] base_vertex;
	logic [19:0] index_start;
	logic [15:0] draw_vertex_count;
	logic [1:0]  draw_primitive;
	logic [19:0] draw_count;
	logic        last;

	modport source(output valid, kind, status, bin_number, base_vertex, index_start,
		draw_vertex_count, draw_primitive, draw_count, last, input ready);
	modport sink(input valid, kind, status, bin_number, base_vertex, index_start,
		draw_vertex_count, draw_primitive, draw_count, last, output ready);
endinterface

@@ hw/rtl/dbb_cfg_if.sv @@
// Configuration write channel of the draw batch binner.
// Depends on nothing but plain logic types.
interface dbb_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [19:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/dbb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module dbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ hw/rtl/draw_batch_binner.sv @@
// Draw batch binner: top level. Holds one RAM row of bins per vertex type.
// Depends on dbb_pkg, the three channel interfaces and dbb_ram.
//
// Usage: requests arrive on req, configuration writes on cfg, result beats
// leave on rsp. Each request gives zero or more draw beats (kind 0), then
// one completion beat (kind 1, last 1). Requests are taken one at a time.
// An add reads the type's row from the bin RAM, picks a bin in parallel
// over the row, optionally flushes the picked bin (also when it must be
// flushed for overflow), writes the row back and reports. A flush of one
// type walks the row one slot per cycle while the output is not stalled,
// then writes the row back and reports; a flush of all bins does this for
// each vertex type in turn. Mode 3, and an invalid vertex type on an add
// or a flush of one type, go straight to the completion beat. The next
// request is taken in the cycle after a completion beat is loaded. The
// RAM port is the limit: one row read and one row write per request
// and row.
// Reset empties every bin at once through one valid bit per row and loads
// the configuration defaults. Results go through a single output register;
// while the receiver stalls, the walk waits on the next beat it must send,
// and no new request is taken until the completion beat has been loaded.
// Configuration writes are always taken and must only come while idle.
module draw_batch_binner #(
	parameter int BINS_PER_TYPE = 8,
	parameter int VERTEX_TYPES  = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	dbb_in_if.sink    req,
	dbb_out_if.source rsp,
	dbb_cfg_if.sink   cfg
);
	localparam int SW    = (BINS_PER_TYPE > 1) ? $clog2(BINS_PER_TYPE) : 1;
	localparam int RW    = (VERTEX_TYPES > 1) ? $clog2(VERTEX_TYPES) : 1;
	localparam int ROW_W = BINS_PER_TYPE * $bits(dbb_pkg::bin_t);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_READ   = 8'b0000_0010,
		S_LOAD   = 8'b0000_0100,
		S_FLUSH  = 8'b0000_1000,
		S_CHOOSE = 8'b0001_0000,
		S_APPLY  = 8'b0010_0000,
		S_WB     = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic [15:0] max_verts_q;
	logic [19:0] max_index_q;
	logic [1:0]  shade_q;

	// Request and walk registers.
	logic [1:0]  mode_q;
	logic [15:0] skin_q;
	logic [15:0] nv_q;
	logic [19:0] eff_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] chosen_q;
	logic [VERTEX_TYPES-1:0] row_valid_q;
	dbb_pkg::bin_t [BINS_PER_TYPE-1:0] work_q;

	// Completion beat contents.
	logic [1:0]  cstatus_q;
	logic [5:0]  cbin_q;
	logic [15:0] cbase_q;
	logic [19:0] cist_q;

	// Output register.
	logic        rsp_valid_q;
	logic        rsp_kind_q;
	logic [1:0]  rsp_status_q;
	logic [5:0]  rsp_bin_q;
	logic [15:0] rsp_base_q;
	logic [19:0] rsp_ist_q;
	logic [15:0] rsp_dverts_q;
	logic [1:0]  rsp_prim_q;
	logic [19:0] rsp_dcount_q;
	logic        rsp_last_q;

	logic [ROW_W-1:0] ram_rdata;
	logic             ram_we, ram_re;

	logic req_fire, cfg_fire, can_emit, want_draw, emit_draw, emit_cmpl;
	logic last_slot, last_row, bad_type;
	logic [SW-1:0] draw_s;

	// Bin choice over the row.
	logic          found, empty_f, pick_flush;
	logic [SW-1:0] match_s, empty_s, full_s, pick_s;

	// Fit checks on the chosen bin.
	logic [15:0] cv;
	logic [19:0] ci;
	logic        too_big, ovf;

	dbb_ram #(.WIDTH(ROW_W), .DEPTH(VERTEX_TYPES)) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (work_q),
		.re    (ram_re),
		.raddr (row_q),
		.rdata (ram_rdata)
	);

	assign ram_we    = (state_q == S_WB);
	assign ram_re    = (state_q == S_READ);
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign can_emit  = !rsp_valid_q || rsp.ready;
	assign last_slot = (slot_q == SW'(BINS_PER_TYPE - 1));
	assign last_row  = (row_q == RW'(VERTEX_TYPES - 1));
	assign bad_type  = (int'(req.vertex_type) >= VERTEX_TYPES);

	// First tag match, last empty bin before it, fullest bin before it.
	always_comb begin
		found   = 1'b0;
		empty_f = 1'b0;
		match_s = '0;
		empty_s = '0;
		full_s  = '0;
		for (int i = 0; i < BINS_PER_TYPE; i++) begin
			if (!found) begin
				if (work_q[i].tag_valid && work_q[i].skin == skin_q) begin
					found   = 1'b1;
					match_s = SW'(i);
				end else begin
					if (work_q[i].vcnt == '0) begin
						empty_f = 1'b1;
						empty_s = SW'(i);
					end
					if (work_q[i].vcnt > work_q[full_s].vcnt) begin
						full_s = SW'(i);
					end
				end
			end
		end
		pick_flush = !found && !empty_f;
		pick_s     = found ? match_s : (empty_f ? empty_s : full_s);
	end

	// Size and overflow tests against the chosen bin.
	assign cv      = work_q[chosen_q].vcnt;
	assign ci      = work_q[chosen_q].icnt;
	assign too_big = (nv_q > max_verts_q) || (eff_q > max_index_q);
	assign ovf     = ({1'b0, nv_q} + {1'b0, cv} > {1'b0, max_verts_q}) ||
		({1'b0, eff_q} + {1'b0, ci} > {1'b0, max_index_q});

	// Which bin a draw beat would come from in this state.
	always_comb begin
		draw_s    = slot_q;
		want_draw = 1'b0;
		unique case (state_q)
			S_FLUSH: begin
				draw_s    = slot_q;
				want_draw = (work_q[slot_q].vcnt != '0);
			end
			S_CHOOSE: begin
				draw_s    = pick_s;
				want_draw = pick_flush;
			end
			S_APPLY: begin
				draw_s    = chosen_q;
				want_draw = !too_big && ovf && (cv != '0);
			end
			default: begin
				draw_s    = slot_q;
				want_draw = 1'b0;
			end
		endcase
	end

	assign emit_draw = want_draw && can_emit;
	assign emit_cmpl = (state_q == S_DONE) && can_emit;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.mode == dbb_pkg::MODE_FLUSH_ALL) begin
						state_d = S_READ;
					end else if (req.mode == dbb_pkg::MODE_RESERVED || bad_type) begin
						state_d = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: state_d = S_LOAD;
			S_LOAD: state_d = (mode_q == dbb_pkg::MODE_ADD) ? S_CHOOSE : S_FLUSH;
			S_FLUSH: begin
				if ((!want_draw || can_emit) && last_slot) begin
					state_d = S_WB;
				end
			end
			S_CHOOSE: begin
				if (!want_draw || can_emit) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (too_big || !ovf) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				if (mode_q == dbb_pkg::MODE_FLUSH_ALL && !last_row) begin
					state_d = S_READ;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (can_emit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers: state, row valid bits, configuration, beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_valid_q <= '0;
			max_verts_q <= 16'd8192;
			max_index_q <= 20'd24576;
			shade_q     <= 2'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				row_valid_q[row_q] <= 1'b1;
			end
			if (cfg_fire) begin
				unique case (cfg.index)
					dbb_pkg::REG_MAX_VERTS:  max_verts_q <= cfg.data[15:0];
					dbb_pkg::REG_MAX_INDEX:  max_index_q <= cfg.data;
					dbb_pkg::REG_SHADE_MODE: shade_q     <= cfg.data[1:0];
					default: ;
				endcase
			end
			if (emit_draw || emit_cmpl) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: request, working row, completion and output beat.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q    <= req.mode;
			skin_q    <= req.skin_id;
			nv_q      <= req.num_verts;
			eff_q     <= req.has_indices ? req.num_indices : {4'd0, req.num_verts};
			row_q     <= (req.mode == dbb_pkg::MODE_FLUSH_ALL) ? '0 : RW'(req.vertex_type);
			cbin_q    <= '0;
			cbase_q   <= '0;
			cist_q    <= '0;
			cstatus_q <= (req.mode != dbb_pkg::MODE_FLUSH_ALL &&
				req.mode != dbb_pkg::MODE_RESERVED && bad_type)
				? dbb_pkg::ST_BAD_TYPE : dbb_pkg::ST_OK;
		end

		case (state_q)
			S_LOAD: begin
				work_q <= row_valid_q[row_q] ? ram_rdata : '0;
				slot_q <= '0;
			end
			S_FLUSH: begin
				if (!want_draw || can_emit) begin
					work_q[slot_q].vcnt <= '0;
					work_q[slot_q].icnt <= '0;
					slot_q <= slot_q + SW'(1);
				end
			end
			S_CHOOSE: begin
				if (!want_draw || can_emit) begin
					chosen_q <= pick_s;
					if (!found) begin
						work_q[pick_s].skin      <= skin_q;
						work_q[pick_s].tag_valid <= 1'b1;
					end
					if (pick_flush) begin
						work_q[pick_s].vcnt <= '0;
						work_q[pick_s].icnt <= '0;
					end
				end
			end
			S_APPLY: begin
				if (too_big) begin
					cstatus_q <= dbb_pkg::ST_TOO_BIG;
					cbin_q    <= dbb_pkg::BIN_W'(int'(row_q) * BINS_PER_TYPE + int'(chosen_q));
				end else if (ovf) begin
					if (!want_draw || can_emit) begin
						work_q[chosen_q].vcnt <= '0;
						work_q[chosen_q].icnt <= '0;
					end
				end else begin
					cbin_q  <= dbb_pkg::BIN_W'(int'(row_q) * BINS_PER_TYPE + int'(chosen_q));
					cbase_q <= cv;
					cist_q  <= ci;
					work_q[chosen_q].vcnt <= cv + nv_q;
					work_q[chosen_q].icnt <= ci + eff_q;
				end
			end
			S_WB: begin
				if (mode_q == dbb_pkg::MODE_FLUSH_ALL && !last_row) begin
					row_q <= row_q + RW'(1);
				end
			end
			default: ;
		endcase

		// Load a draw or completion beat into the output register.
		if (emit_draw) begin
			rsp_kind_q   <= dbb_pkg::KIND_DRAW;
			rsp_status_q <= dbb_pkg::ST_OK;
			rsp_bin_q    <= dbb_pkg::BIN_W'(int'(row_q) * BINS_PER_TYPE + int'(draw_s));
			rsp_base_q   <= '0;
			rsp_ist_q    <= '0;
			rsp_dverts_q <= work_q[draw_s].vcnt;
			if (shade_q == dbb_pkg::SHADE_POINTS) begin
				rsp_prim_q   <= dbb_pkg::PRIM_POINT_LIST;
				rsp_dcount_q <= {4'd0, work_q[draw_s].vcnt};
			end else begin
				rsp_prim_q   <= (shade_q == dbb_pkg::SHADE_HULL_WIRE)
					? dbb_pkg::PRIM_LINE_STRIP : dbb_pkg::PRIM_TRI_LIST;
				rsp_dcount_q <= dbb_pkg::div3(work_q[draw_s].icnt);
			end
			rsp_last_q   <= 1'b0;
		end else if (emit_cmpl) begin
			rsp_kind_q   <= dbb_pkg::KIND_CMPL;
			rsp_status_q <= cstatus_q;
			rsp_bin_q    <= cbin_q;
			rsp_base_q   <= cbase_q;
			rsp_ist_q    <= cist_q;
			rsp_dverts_q <= '0;
			rsp_prim_q   <= dbb_pkg::PRIM_TRI_LIST;
			rsp_dcount_q <= '0;
			rsp_last_q   <= 1'b1;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.kind              = rsp_kind_q;
	assign rsp.status            = rsp_status_q;
	assign rsp.bin_number        = rsp_bin_q;
	assign rsp.base_vertex       = rsp_base_q;
	assign rsp.index_start       = rsp_ist_q;
	assign rsp.draw_vertex_count = rsp_dverts_q;
	assign rsp.draw_primitive    = rsp_prim_q;
	assign rsp.draw_count        = rsp_dcount_q;
	assign rsp.last              = rsp_last_q;

	// A completion beat is the only one that closes a request.
	a_last_is_cmpl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_last_q == rsp_kind_q))
		else $error("last flag does not match beat kind");

	// A draw beat always carries vertices.
	a_draw_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_kind_q == dbb_pkg::KIND_DRAW) |-> (rsp_dverts_q != '0))
		else $error("draw beat with no vertices");

	// Evicting the fullest bin only happens when it holds vertices.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHOOSE && pick_flush) |-> (work_q[pick_s].vcnt != '0))
		else $error("evicted bin was empty");

	// A row write back leaves that row marked valid.
	a_row_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> row_valid_q[$past(row_q)])
		else $error("row valid bit not set after write back");
endmodule
